// ===== hw/rtl/slrd_pkg.sv =====
// Shared types, constants and helpers for the SPI loopback register device.
// No dependencies; imported by every module of the block but slrd_fifo_ram.
package slrd_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Payload widths
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int STATE_W = 3;
    localparam int TICK_W  = 4;

    // Tick counter wraps at ten
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(9);

    // Register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_CTRL1  = 8'h00;
    localparam logic [ADDR_W-1:0] ADDR_CTRL2  = 8'h04;
    localparam logic [ADDR_W-1:0] ADDR_STATUS = 8'h08;
    localparam logic [ADDR_W-1:0] ADDR_DATA   = 8'h0C;

    // Reset values
    localparam logic [DATA_W-1:0] CTRL2_RESET  = 32'h0000_0700;
    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0002;

    // Bit positions
    localparam int CTRL1_RUN_BIT   = 6;
    localparam int STAT_RX_AVAIL   = 0;
    localparam int STAT_TX_SPACE   = 1;
    localparam int STAT_ERR_BIT_A  = 4;
    localparam int STAT_ERR_BIT_B  = 5;
    localparam int STAT_ERR_BIT_C  = 6;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Memory commands issued when an item is accepted
    typedef struct packed {
        logic              tx_we;
        logic [PTR_W-1:0]  tx_waddr;
        logic [BYTE_W-1:0] tx_wdata;
        logic              tx_re;
        logic [PTR_W-1:0]  tx_raddr;
        logic              rx_re;
        logic [PTR_W-1:0]  rx_raddr;
    } t_mem_cmd;

    // Item context carried into the memory read stage
    typedef struct packed {
        logic               mosi_valid;
        logic               rx_rd;
        logic               rx_wr;
        logic [PTR_W-1:0]   rx_wr_addr;
        logic [DATA_W-1:0]  reg_rdata;
        logic [STATE_W-1:0] fsm_state;
    } t_s1;

    // Ring pointer plus offset, modulo the FIFO depth
    function automatic logic [PTR_W-1:0] fifo_wrap(input logic [PTR_W-1:0] head,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
            sum = sum - (CNT_W+1)'(FIFO_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

// ===== hw/rtl/slrd_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on slrd_pkg for payload widths.
interface slrd_in_if;
    import slrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, output op, output addr, output wdata, input ready);
    modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface slrd_out_if;
    import slrd_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  rdata;
    logic               mosi_valid;
    logic [BYTE_W-1:0]  mosi_byte;
    logic [STATE_W-1:0] fsm_state;

    modport source (output valid, output rdata, output mosi_valid, output mosi_byte,
                    output fsm_state, input ready);
    modport sink   (input valid, input rdata, input mosi_valid, input mosi_byte,
                    input fsm_state, output ready);
endinterface

// ===== hw/rtl/slrd_fifo_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; used for the transmit and receive FIFO stores.
module slrd_fifo_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-cycle collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/slrd_ctrl.sv =====
// Register file, FIFO pointers and the link state machine of the device.
// Depends on slrd_pkg; issues FIFO memory commands and the item context.
module slrd_ctrl
    import slrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output t_mem_cmd          o_cmd,
    output t_s1               o_s1
);
    typedef enum logic [STATE_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_TX       = 3'd1,
        ST_RX       = 3'd2,
        ST_ERROR    = 3'd4,
        ST_RECOVERY = 3'd5
    } t_state;

    t_state            r_state,   n_state;
    logic [DATA_W-1:0] r_ctrl1,   n_ctrl1;
    logic [DATA_W-1:0] r_ctrl2,   n_ctrl2;
    logic [DATA_W-1:0] r_status,  n_status;
    logic [PTR_W-1:0]  r_tx_head, n_tx_head;
    logic [CNT_W-1:0]  r_tx_cnt,  n_tx_cnt;
    logic [PTR_W-1:0]  r_rx_head, n_rx_head;
    logic [CNT_W-1:0]  r_rx_cnt,  n_rx_cnt;
    logic [TICK_W-1:0] r_tick,    n_tick;

    // Decode one item and compute the next register state
    always_comb begin
        n_state   = r_state;
        n_ctrl1   = r_ctrl1;
        n_ctrl2   = r_ctrl2;
        n_status  = r_status;
        n_tx_head = r_tx_head;
        n_tx_cnt  = r_tx_cnt;
        n_rx_head = r_rx_head;
        n_rx_cnt  = r_rx_cnt;
        n_tick    = r_tick;
        o_cmd     = '0;
        o_s1      = '0;

        if (i_accept) begin
            unique case (i_op)
                OP_TICK: begin
                    n_tick = (r_tick == TICK_LAST) ? '0 : r_tick + TICK_W'(1);
                    if (!r_ctrl1[CTRL1_RUN_BIT]) begin
                        n_state = ST_IDLE;
                    end else begin
                        unique case (r_state)
                            ST_IDLE: begin
                                if (r_tx_cnt != '0 || r_status[STAT_TX_SPACE]) begin
                                    n_state = ST_TX;
                                end
                            end
                            ST_TX: begin
                                // Pop one byte and loop its inverse back
                                if (r_tx_cnt != '0) begin
                                    o_cmd.tx_re     = 1'b1;
                                    o_cmd.tx_raddr  = r_tx_head;
                                    n_tx_head       = fifo_wrap(r_tx_head, CNT_W'(1));
                                    n_tx_cnt        = r_tx_cnt - CNT_W'(1);
                                    o_s1.mosi_valid = 1'b1;
                                    if (r_rx_cnt < CNT_W'(FIFO_DEPTH)) begin
                                        o_s1.rx_wr      = 1'b1;
                                        o_s1.rx_wr_addr = fifo_wrap(r_rx_head, r_rx_cnt);
                                        n_rx_cnt        = r_rx_cnt + CNT_W'(1);
                                    end
                                end
                                if (n_tx_cnt == '0 && !r_status[STAT_TX_SPACE]) begin
                                    n_state = (n_rx_cnt != '0) ? ST_RX : ST_IDLE;
                                end
                            end
                            ST_RX: begin
                                if (r_rx_cnt != '0) begin
                                    n_status[STAT_RX_AVAIL] = 1'b1;
                                end else begin
                                    n_status[STAT_RX_AVAIL] = 1'b0;
                                    n_state = ST_IDLE;
                                end
                            end
                            ST_ERROR: begin
                                if (!r_status[STAT_ERR_BIT_A] && !r_status[STAT_ERR_BIT_B]
                                    && !r_status[STAT_ERR_BIT_C]) begin
                                    n_state = ST_RECOVERY;
                                end
                            end
                            ST_RECOVERY: begin
                                if (n_tick == '0) begin
                                    n_state = ST_IDLE;
                                end
                            end
                            default: begin
                            end
                        endcase
                        n_status[STAT_TX_SPACE] = (n_tx_cnt < CNT_W'(FIFO_DEPTH));
                    end
                end
                OP_WRITE: begin
                    unique case (i_addr)
                        ADDR_CTRL1:  n_ctrl1  = i_wdata;
                        ADDR_CTRL2:  n_ctrl2  = i_wdata;
                        ADDR_STATUS: n_status = i_wdata;
                        ADDR_DATA: begin
                            // Push the low byte; drop it when full
                            if (r_tx_cnt < CNT_W'(FIFO_DEPTH)) begin
                                o_cmd.tx_we    = 1'b1;
                                o_cmd.tx_waddr = fifo_wrap(r_tx_head, r_tx_cnt);
                                o_cmd.tx_wdata = i_wdata[BYTE_W-1:0];
                                n_tx_cnt       = r_tx_cnt + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_READ: begin
                    unique case (i_addr)
                        ADDR_CTRL1:  o_s1.reg_rdata = r_ctrl1;
                        ADDR_CTRL2:  o_s1.reg_rdata = r_ctrl2;
                        ADDR_STATUS: o_s1.reg_rdata = r_status;
                        ADDR_DATA: begin
                            // Pop the receive FIFO; data follows from memory
                            if (r_rx_cnt != '0) begin
                                o_cmd.rx_re    = 1'b1;
                                o_cmd.rx_raddr = r_rx_head;
                                o_s1.rx_rd     = 1'b1;
                                n_rx_head      = fifo_wrap(r_rx_head, CNT_W'(1));
                                n_rx_cnt       = r_rx_cnt - CNT_W'(1);
                                if (n_rx_cnt == '0) begin
                                    n_status[STAT_RX_AVAIL] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        o_s1.fsm_state = n_state;
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ctrl1   <= '0;
            r_ctrl2   <= CTRL2_RESET;
            r_status  <= STATUS_RESET;
            r_tx_head <= '0;
            r_tx_cnt  <= '0;
            r_rx_head <= '0;
            r_rx_cnt  <= '0;
            r_tick    <= '0;
        end else begin
            r_state   <= n_state;
            r_ctrl1   <= n_ctrl1;
            r_ctrl2   <= n_ctrl2;
            r_status  <= n_status;
            r_tx_head <= n_tx_head;
            r_tx_cnt  <= n_tx_cnt;
            r_rx_head <= n_rx_head;
            r_rx_cnt  <= n_rx_cnt;
            r_tick    <= n_tick;
        end
    end
endmodule

// ===== hw/rtl/spi_loopback_register_device_core.sv =====
// Top level of the SPI loopback register device: pipeline, FIFO memories, result register.
// Depends on slrd_pkg, slrd_if, slrd_ctrl and slrd_fifo_ram.

// Takes one tick, register write or register read per clock and returns one result per item.
// On acceptance the control registers update and the transmit and receive FIFO memories
// register their read byte beside the item context; the result then moves into an output
// register as the read stage advances. The sustained rate is one item per cycle; an item
// waits only while the output register is full and not being taken. The byte looped back
// from a transmit pop is written to the receive memory in the read stage and forwarded to
// an immediately following data read of the same entry.
module spi_loopback_register_device_core
    import slrd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    slrd_in_if.sink      i_in,
    slrd_out_if.source   o_out
);
    t_mem_cmd           cmd;
    t_s1                s1_next;
    t_s1                r_s1;
    logic               r_s1_valid;
    logic               s1_adv;
    logic               accept;
    logic [BYTE_W-1:0]  tx_rdata;
    logic [BYTE_W-1:0]  rx_rdata;
    logic [BYTE_W-1:0]  loop_byte;
    logic               rx_we;
    logic               r_fwd_hit;
    logic [BYTE_W-1:0]  r_fwd_byte;
    logic [BYTE_W-1:0]  rx_byte;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_rdata;
    logic               r_out_mosi_valid;
    logic [BYTE_W-1:0]  r_out_mosi_byte;
    logic [STATE_W-1:0] r_out_fsm_state;

    // Advance the read stage when the output register is free or drained
    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    slrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_op    (i_in.op),
        .i_addr  (i_in.addr),
        .i_wdata (i_in.wdata),
        .o_cmd   (cmd),
        .o_s1    (s1_next)
    );

    slrd_fifo_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .i_clk  (i_clk),
        .i_we   (cmd.tx_we),
        .i_waddr(cmd.tx_waddr),
        .i_wdata(cmd.tx_wdata),
        .i_re   (cmd.tx_re),
        .i_raddr(cmd.tx_raddr),
        .o_rdata(tx_rdata)
    );

    // Loop the inverted transmit byte into the receive store
    assign loop_byte = tx_rdata ^ BYTE_MASK;
    assign rx_we     = r_s1_valid && s1_adv && r_s1.rx_wr;

    slrd_fifo_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .i_clk  (i_clk),
        .i_we   (rx_we),
        .i_waddr(r_s1.rx_wr_addr),
        .i_wdata(loop_byte),
        .i_re   (cmd.rx_re),
        .i_raddr(cmd.rx_raddr),
        .o_rdata(rx_rdata)
    );

    // Forward a loopback write that collides with the next receive pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (accept) begin
            r_fwd_hit <= cmd.rx_re && rx_we && (r_s1.rx_wr_addr == cmd.rx_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_byte <= loop_byte;
        end
    end

    assign rx_byte = r_fwd_hit ? r_fwd_byte : rx_rdata;

    // Hold the item context while the memories read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= s1_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_rdata      <= r_s1.rx_rd ? DATA_W'(rx_byte) : r_s1.reg_rdata;
            r_out_mosi_valid <= r_s1.mosi_valid;
            r_out_mosi_byte  <= r_s1.mosi_valid ? tx_rdata : '0;
            r_out_fsm_state  <= r_s1.fsm_state;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.rdata      = r_out_rdata;
    assign o_out.mosi_valid = r_out_mosi_valid;
    assign o_out.mosi_byte  = r_out_mosi_byte;
    assign o_out.fsm_state  = r_out_fsm_state;
endmodule

// ===== tb/sv/tb_spi_loopback_register_device_core.sv =====
// Self-checking testbench for the SPI loopback register device core.
// Depends on slrd_pkg, slrd_if and the RTL of spi_loopback_register_device_core.
module tb_spi_loopback_register_device_core;
    import slrd_pkg::*;

    // Machine state codes as seen on fsm_state
    localparam logic [STATE_W-1:0] FSM_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] FSM_TX       = 3'd1;
    localparam logic [STATE_W-1:0] FSM_RX       = 3'd2;
    localparam logic [STATE_W-1:0] FSM_ERROR    = 3'd4;
    localparam logic [STATE_W-1:0] FSM_RECOVERY = 3'd5;

    localparam int ITEM_TARGET  = 1450;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int PRESSURE_LEN = 300;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic               mosi_valid;
        logic [BYTE_W-1:0]  mosi_byte;
        logic [STATE_W-1:0] fsm_state;
    } t_dev_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slrd_in_if  in_ch();
    slrd_out_if out_ch();

    spi_loopback_register_device_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Device state as predicted from the accepted transfers
    logic [DATA_W-1:0]  dev_ctrl1;
    logic [DATA_W-1:0]  dev_ctrl2;
    logic [DATA_W-1:0]  dev_status;
    logic [BYTE_W-1:0]  tx_bytes [FIFO_DEPTH];
    logic [BYTE_W-1:0]  rx_bytes [FIFO_DEPTH];
    logic [PTR_W-1:0]   tx_rd_ptr;
    logic [CNT_W-1:0]   tx_fill;
    logic [PTR_W-1:0]   rx_rd_ptr;
    logic [CNT_W-1:0]   rx_fill;
    logic [STATE_W-1:0] dev_fsm;
    logic [TICK_W-1:0]  tick_phase;

    t_dev_result pending_results[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int hold_len       = 0;
    int stall_left     = 0;
    bit steady_burst   = 1'b0;

    logic [ADDR_W-1:0] reg_offsets [4] = '{ADDR_CTRL1, ADDR_CTRL2, ADDR_STATUS, ADDR_DATA};

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute the result of one transfer and advance the predicted state
    function automatic t_dev_result step_device(input t_op op, input logic [ADDR_W-1:0] addr,
                                                input logic [DATA_W-1:0] wdata);
        t_dev_result res;
        logic [BYTE_W-1:0] sent;
        res = '0;
        case (op)
            OP_TICK: begin
                tick_phase = (tick_phase == TICK_LAST) ? '0 : tick_phase + TICK_W'(1);
                if (!dev_ctrl1[CTRL1_RUN_BIT]) begin
                    dev_fsm = FSM_IDLE;
                end else begin
                    case (dev_fsm)
                        FSM_IDLE: begin
                            if (tx_fill != 0 || dev_status[STAT_TX_SPACE]) dev_fsm = FSM_TX;
                        end
                        FSM_TX: begin
                            if (tx_fill != 0) begin
                                sent = tx_bytes[tx_rd_ptr];
                                tx_rd_ptr = tx_rd_ptr + PTR_W'(1);
                                tx_fill = tx_fill - CNT_W'(1);
                                res.mosi_valid = 1'b1;
                                res.mosi_byte = sent;
                                // drop the looped byte when the receive side is full
                                if (rx_fill < CNT_W'(FIFO_DEPTH)) begin
                                    rx_bytes[PTR_W'(CNT_W'(rx_rd_ptr) + rx_fill)] =
                                        sent ^ BYTE_MASK;
                                    rx_fill = rx_fill + CNT_W'(1);
                                end
                            end
                            if (tx_fill == 0 && !dev_status[STAT_TX_SPACE]) begin
                                dev_fsm = (rx_fill != 0) ? FSM_RX : FSM_IDLE;
                            end
                        end
                        FSM_RX: begin
                            if (rx_fill != 0) begin
                                dev_status[STAT_RX_AVAIL] = 1'b1;
                            end else begin
                                dev_status[STAT_RX_AVAIL] = 1'b0;
                                dev_fsm = FSM_IDLE;
                            end
                        end
                        FSM_ERROR: begin
                            if (!dev_status[STAT_ERR_BIT_A] && !dev_status[STAT_ERR_BIT_B] &&
                                !dev_status[STAT_ERR_BIT_C]) dev_fsm = FSM_RECOVERY;
                        end
                        FSM_RECOVERY: begin
                            if (tick_phase == 0) dev_fsm = FSM_IDLE;
                        end
                        default: begin
                        end
                    endcase
                    dev_status[STAT_TX_SPACE] = (tx_fill < CNT_W'(FIFO_DEPTH));
                end
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_CTRL1:  dev_ctrl1 = wdata;
                    ADDR_CTRL2:  dev_ctrl2 = wdata;
                    ADDR_STATUS: dev_status = wdata;
                    ADDR_DATA: begin
                        // a full transmit side drops the byte
                        if (tx_fill < CNT_W'(FIFO_DEPTH)) begin
                            tx_bytes[PTR_W'(CNT_W'(tx_rd_ptr) + tx_fill)] = wdata[BYTE_W-1:0];
                            tx_fill = tx_fill + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                case (addr)
                    ADDR_CTRL1:  res.rdata = dev_ctrl1;
                    ADDR_CTRL2:  res.rdata = dev_ctrl2;
                    ADDR_STATUS: res.rdata = dev_status;
                    ADDR_DATA: begin
                        if (rx_fill != 0) begin
                            res.rdata = DATA_W'(rx_bytes[rx_rd_ptr]);
                            rx_rd_ptr = rx_rd_ptr + PTR_W'(1);
                            rx_fill = rx_fill - CNT_W'(1);
                            if (rx_fill == 0) dev_status[STAT_RX_AVAIL] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.fsm_state = dev_fsm;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        end
    endtask

    // Predict on each accepted request, then check each accepted result
    always @(posedge i_clk) begin
        t_dev_result want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                pending_results.push_back(step_device(t_op'(in_ch.op), in_ch.addr, in_ch.wdata));
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, rdata", out_ch.rdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.rdata !== want.rdata)
                        report_mismatch("rdata", out_ch.rdata, want.rdata);
                    if (out_ch.mosi_valid !== want.mosi_valid)
                        report_mismatch("mosi_valid", DATA_W'(out_ch.mosi_valid),
                                        DATA_W'(want.mosi_valid));
                    if (out_ch.mosi_byte !== want.mosi_byte)
                        report_mismatch("mosi_byte", DATA_W'(out_ch.mosi_byte),
                                        DATA_W'(want.mosi_byte));
                    if (out_ch.fsm_state !== want.fsm_state)
                        report_mismatch("fsm_state", DATA_W'(out_ch.fsm_state),
                                        DATA_W'(want.fsm_state));
                end
            end
        end
    end

    function automatic int pick_stall();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            out_ch.ready <= 1'b0;
            hold_len--;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = pick_stall();
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one request and hold it until the transfer happens
    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.addr  <= addr;
        in_ch.wdata <= wdata;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        send_item(OP_WRITE, addr, value);
    endtask

    task automatic read_reg(input logic [ADDR_W-1:0] addr);
        send_item(OP_READ, addr, $urandom);
    endtask

    task automatic tick();
        send_item(OP_TICK, ADDR_W'($urandom), $urandom);
    endtask

    // Reset values, a write read-back, an unmapped offset and an empty data read
    task automatic test_register_access();
        read_reg(ADDR_CTRL2);
        read_reg(ADDR_STATUS);
        write_reg(ADDR_CTRL2, '1);
        read_reg(ADDR_CTRL2);
        write_reg(8'hFF, '1);
        read_reg(8'hFF);
        read_reg(ADDR_DATA);
    endtask

    // Push two bytes, shift them out, walk to receive and drain the loopback
    task automatic test_loopback_path();
        write_reg(ADDR_CTRL1, 32'h0000_0040);
        write_reg(ADDR_DATA, 32'hFFFF_FF00);
        write_reg(ADDR_DATA, 32'h0000_00FF);
        tick();
        tick();
        tick();
        tick();
        write_reg(ADDR_STATUS, '0);
        tick();
        tick();
        read_reg(ADDR_STATUS);
        read_reg(ADDR_DATA);
        read_reg(ADDR_DATA);
        read_reg(ADDR_DATA);
        tick();
    endtask

    // Clearing the run bit sends the machine back to idle
    task automatic test_run_disable();
        tick();
        write_reg(ADDR_CTRL1, 32'hFFFF_FFBF);
        tick();
        read_reg(ADDR_CTRL1);
    endtask

    // Hold off the result side long enough for the request side to stall
    task automatic test_backpressure();
        logic [DATA_W-1:0] v;
        v = $urandom;
        v[CTRL1_RUN_BIT] = 1'b1;
        steady_burst = 1'b1;
        write_reg(ADDR_CTRL1, v);
        hold_len = PRESSURE_LEN;
        repeat (20) begin
            write_reg(ADDR_DATA, $urandom);
            tick();
        end
        steady_burst = 1'b0;
    endtask

    // Mostly well-formed bursts with random content, some noise
    task automatic test_random_traffic();
        logic [DATA_W-1:0] v;
        logic [ADDR_W-1:0] a;
        int kind;
        v = $urandom;
        v[CTRL1_RUN_BIT] = 1'b1;
        write_reg(ADDR_CTRL1, v);
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            steady_burst = ($urandom_range(0, 3) == 0);
            case (kind)
                0, 1, 2: repeat ($urandom_range(1, 18)) write_reg(ADDR_DATA, $urandom);
                3, 4, 5: repeat ($urandom_range(1, 20)) tick();
                6:       repeat ($urandom_range(1, 18)) read_reg(ADDR_DATA);
                7: begin
                    write_reg(ADDR_STATUS, $urandom);
                    if ($urandom_range(0, 1) == 0) read_reg(ADDR_STATUS);
                end
                8: begin
                    v = $urandom;
                    v[CTRL1_RUN_BIT] = ($urandom_range(0, 4) != 0);
                    write_reg(ADDR_CTRL1, v);
                    read_reg(ADDR_CTRL1);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        a = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom)
                                                         : reg_offsets[$urandom_range(0, 3)];
                        send_item(t_op'($urandom_range(0, 2)), a, $urandom);
                    end
                end
            endcase
        end
        steady_burst = 1'b0;
    endtask

    // Run limit
    initial begin
        #6000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int guard;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op    = OP_TICK;
        in_ch.addr  = '0;
        in_ch.wdata = '0;

        dev_ctrl1  = '0;
        dev_ctrl2  = CTRL2_RESET;
        dev_status = STATUS_RESET;
        tx_rd_ptr  = '0;
        tx_fill    = '0;
        rx_rd_ptr  = '0;
        rx_fill    = '0;
        dev_fsm    = FSM_IDLE;
        tick_phase = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_loopback_path();
        test_run_disable();
        test_backpressure();
        test_random_traffic();

        // Drain outstanding results
        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            report_mismatch("result never arrived, count", '0, '0);
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== spi_loopback_register_device_core.f =====
hw/rtl/slrd_pkg.sv
hw/rtl/slrd_if.sv
hw/rtl/slrd_fifo_ram.sv
hw/rtl/slrd_ctrl.sv
hw/rtl/spi_loopback_register_device_core.sv
tb/sv/tb_spi_loopback_register_device_core.sv
